// ----- rtl/flow_vector_color_coder_top_assert.svh -----
// Assertion macros for the color coder checker
`ifndef FLOW_VECTOR_COLOR_CODER_TOP_ASSERT_SVH
`define FLOW_VECTOR_COLOR_CODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FVCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FVCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fvcc_pkg.sv -----
// Shared constants, types and tables of the flow vector color coder
`timescale 1ns / 1ps
`default_nettype none
package fvcc_pkg;

  localparam int FLOW_WIDTH     = 16;
  localparam int FLOW_FRAC_BITS = 5;
  localparam int MAG_W          = FLOW_WIDTH;
  localparam int LEN_W          = FLOW_WIDTH + 1;
  localparam int SQ_W           = 2 * LEN_W;
  localparam int ROOT_W         = 32;
  localparam int CNT_W          = 6;
  localparam int CORDIC_STEPS   = 16;
  localparam int STEP_W         = 4;
  localparam int CORDIC_SHIFT   = 14;
  localparam int CORDIC_XW      = 34;
  localparam int CORDIC_ZW      = 21;
  localparam int ATAN_W         = 18;
  localparam int ANG_W          = 20;
  localparam int QANG_W         = 19;
  localparam int QUARTER_TURN   = 262144;
  localparam int HALF_TURN      = 524288;
  localparam int FULL_TURN      = 1048576;
  localparam int WHEEL_LAST     = 54;
  localparam int WK_W           = 6;
  localparam int COLOR_W        = 8;
  localparam int RQ_W           = 17;
  localparam int FK_W           = 22;
  localparam int MIX_W          = 25;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic start;
    logic op_div;
  } unit_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // atan(2^-i) as a fraction of a turn, Q20
  function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      4'd0:    a = 18'd131072;
      4'd1:    a = 18'd77376;
      4'd2:    a = 18'd40884;
      4'd3:    a = 18'd20753;
      4'd4:    a = 18'd10417;
      4'd5:    a = 18'd5213;
      4'd6:    a = 18'd2607;
      4'd7:    a = 18'd1304;
      4'd8:    a = 18'd652;
      4'd9:    a = 18'd326;
      4'd10:   a = 18'd163;
      4'd11:   a = 18'd81;
      4'd12:   a = 18'd41;
      4'd13:   a = 18'd20;
      4'd14:   a = 18'd10;
      default: a = 18'd5;
    endcase
    return a;
  endfunction

  // 255*i/6 rounded down
  function automatic int unsigned ramp_six(input int unsigned i);
    int unsigned v;
    case (i)
      0:       v = 0;
      1:       v = 42;
      2:       v = 85;
      3:       v = 127;
      4:       v = 170;
      default: v = 212;
    endcase
    return v;
  endfunction

  // 255*i/4 rounded down
  function automatic int unsigned ramp_four(input int unsigned i);
    int unsigned v;
    case (i)
      0:       v = 0;
      1:       v = 63;
      2:       v = 127;
      default: v = 191;
    endcase
    return v;
  endfunction

  // 255*i/11 rounded down
  function automatic int unsigned ramp_eleven(input int unsigned i);
    int unsigned v;
    case (i)
      0:       v = 0;
      1:       v = 23;
      2:       v = 46;
      3:       v = 69;
      4:       v = 92;
      5:       v = 115;
      6:       v = 139;
      7:       v = 162;
      8:       v = 185;
      9:       v = 208;
      default: v = 231;
    endcase
    return v;
  endfunction

  // 255*i/13 rounded down
  function automatic int unsigned ramp_thirteen(input int unsigned i);
    int unsigned v;
    case (i)
      0:       v = 0;
      1:       v = 19;
      2:       v = 39;
      3:       v = 58;
      4:       v = 78;
      5:       v = 98;
      6:       v = 117;
      7:       v = 137;
      8:       v = 156;
      9:       v = 176;
      10:      v = 196;
      11:      v = 215;
      default: v = 235;
    endcase
    return v;
  endfunction

  // One channel of the 55-entry color wheel
  function automatic logic [COLOR_W-1:0] wheel_ch(input logic [WK_W-1:0] k,
                                                   input logic [1:0] ch);
    int unsigned kk;
    int unsigned i;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    kk = k;
    if (kk > WHEEL_LAST) kk = 0;
    if (kk < 15) begin
      i = kk; r = 255; g = 17 * i; b = 0;
    end else if (kk < 21) begin
      i = kk - 15; r = 255 - ramp_six(i); g = 255; b = 0;
    end else if (kk < 25) begin
      i = kk - 21; r = 0; g = 255; b = ramp_four(i);
    end else if (kk < 36) begin
      i = kk - 25; r = 0; g = 255 - ramp_eleven(i); b = 255;
    end else if (kk < 49) begin
      i = kk - 36; r = ramp_thirteen(i); g = 0; b = 255;
    end else begin
      i = kk - 49; r = 255; g = 0; b = 255 - ramp_six(i);
    end
    case (ch)
      CH_RED:   return COLOR_W'(r);
      CH_GREEN: return COLOR_W'(g);
      default:  return COLOR_W'(b);
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fvcc_root_div.sv -----
// Shared restoring unit: integer square root or fractional divide, one bit a cycle
`timescale 1ns / 1ps
`default_nettype none
module fvcc_root_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fvcc_pkg::unit_cmd_t         cmd,
  input  wire logic [fvcc_pkg::SQ_W-1:0]   a_in,
  input  wire logic [fvcc_pkg::SQ_W-1:0]   div_in,
  output fvcc_pkg::unit_stat_t             stat,
  output logic [fvcc_pkg::ROOT_W-1:0]      result
);

  localparam int RW         = fvcc_pkg::SQ_W + 1;
  localparam int DIV_STEPS  = fvcc_pkg::ROOT_W;
  localparam int ROOT_STEPS = fvcc_pkg::ROOT_W / 2;

  logic                          op_r, op_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [fvcc_pkg::ROOT_W-1:0]   res_r, res_nxt;
  logic [fvcc_pkg::ROOT_W-1:0]   bit_r, bit_nxt;
  logic [fvcc_pkg::SQ_W-1:0]     div_r, div_nxt;
  logic [fvcc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  logic [RW-1:0] trial;
  logic [RW-1:0] sub;
  logic [RW-1:0] diff;
  logic          ge;

  always_comb begin
    trial = op_r ? {rem_r[RW-2:0], 1'b0} : rem_r;
    sub   = op_r ? {1'b0, div_r} : (RW'(res_r) + RW'(bit_r));
    ge    = (trial >= sub);
    diff  = trial - sub;
  end

  always_comb begin
    op_nxt   = op_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      op_nxt   = cmd.op_div;
      rem_nxt  = {1'b0, a_in};
      res_nxt  = '0;
      bit_nxt  = fvcc_pkg::ROOT_W'(1) << (fvcc_pkg::ROOT_W - 2);
      div_nxt  = div_in;
      cnt_nxt  = cmd.op_div ? fvcc_pkg::CNT_W'(DIV_STEPS) : fvcc_pkg::CNT_W'(ROOT_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff : trial;
      if (op_r) begin
        res_nxt = {res_r[fvcc_pkg::ROOT_W-2:0], ge};
      end else begin
        res_nxt = ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fvcc_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = res_r;

endmodule
`default_nettype wire

// ----- rtl/fvcc_cordic.sv -----
// Iterative CORDIC vectoring unit: first-quadrant angle in Q20 turns
`timescale 1ns / 1ps
`default_nettype none
module fvcc_cordic (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [fvcc_pkg::MAG_W-1:0]   ax,
  input  wire logic [fvcc_pkg::MAG_W-1:0]   ay,
  output fvcc_pkg::unit_stat_t              stat,
  output logic [fvcc_pkg::QANG_W-1:0]       angle
);

  localparam int XW = fvcc_pkg::CORDIC_XW;
  localparam int ZW = fvcc_pkg::CORDIC_ZW;

  logic signed [XW-1:0]              x_r, x_nxt;
  logic signed [XW-1:0]              y_r, y_nxt;
  logic signed [ZW-1:0]              z_r, z_nxt;
  logic [fvcc_pkg::STEP_W-1:0]       i_r, i_nxt;
  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;

  logic signed [XW-1:0] xa;
  logic signed [XW-1:0] ya;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] at;

  // shifts round toward zero
  always_comb begin
    ya = y_r[XW-1] ? -y_r : y_r;
    xa = x_r[XW-1] ? -x_r : x_r;
    dx = y_r[XW-1] ? -(ya >>> i_r) : (ya >>> i_r);
    dy = x_r[XW-1] ? -(xa >>> i_r) : (xa >>> i_r);
    at = signed'(ZW'(fvcc_pkg::atan_turn(i_r)));
  end

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = signed'(XW'({ax, {fvcc_pkg::CORDIC_SHIFT{1'b0}}}));
      y_nxt    = signed'(XW'({ay, {fvcc_pkg::CORDIC_SHIFT{1'b0}}}));
      z_nxt    = '0;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + at;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == fvcc_pkg::STEP_W'(fvcc_pkg::CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      i_r    <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  // clamp to [0, quarter turn]
  always_comb begin
    if (z_r[ZW-1]) begin
      angle = '0;
    end else if (z_r > ZW'(fvcc_pkg::QUARTER_TURN)) begin
      angle = fvcc_pkg::QANG_W'(fvcc_pkg::QUARTER_TURN);
    end else begin
      angle = z_r[fvcc_pkg::QANG_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ----- rtl/flow_vector_color_coder_top.sv -----
// Flow vector color coder: sequencer, shared multiplier and color shading
// Measure pass: two squaring steps, then a 16-step square root.
// Paint pass inside radius 1: 32-step divide then 16-step root on the shared
// restoring unit, then mix and shade per channel; beyond radius 1 no divide or root.
// Throughput: one item at a time; the next item is taken once the current one is done.
// Reset (rst_n low, synchronous): sequencer idle, stored maximum and max_motion cleared.
`timescale 1ns / 1ps
`default_nettype none
module flow_vector_color_coder_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [15:0]                           cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_mode,
  input  wire logic                                  in_frame_start,
  input  wire logic signed [fvcc_pkg::FLOW_WIDTH-1:0] in_flow_u,
  input  wire logic signed [fvcc_pkg::FLOW_WIDTH-1:0] in_flow_v,
  input  wire logic                                  in_unknown,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [fvcc_pkg::COLOR_W-1:0]               out_red,
  output logic [fvcc_pkg::COLOR_W-1:0]               out_green,
  output logic [fvcc_pkg::COLOR_W-1:0]               out_blue,
  output logic [15:0]                                out_longest
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_SQ_U   = 12'b0000_0000_0010,
    S_SQ_V   = 12'b0000_0000_0100,
    S_ROOT   = 12'b0000_0000_1000,
    S_NSQ    = 12'b0000_0001_0000,
    S_DECIDE = 12'b0000_0010_0000,
    S_DIV    = 12'b0000_0100_0000,
    S_QROOT  = 12'b0000_1000_0000,
    S_ANGLE  = 12'b0001_0000_0000,
    S_MIX    = 12'b0010_0000_0000,
    S_SHADE  = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  localparam int MW  = fvcc_pkg::MAG_W;
  localparam int LW  = fvcc_pkg::LEN_W;
  localparam int SW  = fvcc_pkg::SQ_W;
  localparam int CW  = fvcc_pkg::COLOR_W;
  localparam int AW  = fvcc_pkg::ANG_W;
  localparam int NW  = 41;

  state_t                       state_r, state_nxt;
  logic                         mode_r, mode_nxt;
  logic                         u_neg_r, u_neg_nxt;
  logic                         v_neg_r, v_neg_nxt;
  logic [MW-1:0]                au_r, au_nxt;
  logic [MW-1:0]                av_r, av_nxt;
  logic [SW-1:0]                s_r, s_nxt;
  logic [SW-1:0]                n2_r, n2_nxt;
  logic                         far_r, far_nxt;
  logic [fvcc_pkg::RQ_W-1:0]    rq_r, rq_nxt;
  logic [fvcc_pkg::FK_W-1:0]    fk_r, fk_nxt;
  logic [fvcc_pkg::MIX_W-1:0]   c_r, c_nxt;
  logic [1:0]                   ch_r, ch_nxt;
  logic [CW-1:0]                red_r, red_nxt;
  logic [CW-1:0]                green_r, green_nxt;
  logic [CW-1:0]                blue_r, blue_nxt;
  logic [LW-1:0]                longest_r, longest_nxt;
  logic [15:0]                  max_motion_r;
  logic                         ang_rdy_r, ang_rdy_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [CW-1:0]                out_red_r, out_red_nxt;
  logic [CW-1:0]                out_green_r, out_green_nxt;
  logic [CW-1:0]                out_blue_r, out_blue_nxt;
  logic [15:0]                  out_longest_r, out_longest_nxt;

  logic                         in_acc;
  logic [MW-1:0]                in_au;
  logic [MW-1:0]                in_av;
  logic [LW-1:0]                mul_a;
  logic [LW-1:0]                mul_b;
  logic [SW-1:0]                prod;
  logic [SW-1:0]                sum_sq;
  logic [LW-1:0]                n_sel;

  fvcc_pkg::unit_cmd_t          unit_cmd;
  fvcc_pkg::unit_stat_t         unit_stat;
  logic [SW-1:0]                unit_a;
  logic [fvcc_pkg::ROOT_W-1:0]  unit_res;

  logic                         cordic_start;
  fvcc_pkg::unit_stat_t         cordic_stat;
  logic [fvcc_pkg::QANG_W-1:0]  cordic_angle;

  logic [fvcc_pkg::QANG_W-1:0]  q_ang;
  logic [AW:0]                  phi_w;
  logic [AW-1:0]                phi;
  logic [fvcc_pkg::WK_W-1:0]    k0;
  logic [fvcc_pkg::WK_W-1:0]    k1;
  logic [15:0]                  frac;
  logic [16:0]                  omf;
  logic [CW-1:0]                w0;
  logic [CW-1:0]                w1;
  logic [26:0]                  far3;
  logic [23:0]                  shade_gap;
  logic [NW-1:0]                near_p;
  logic [NW-1:0]                near_v;
  logic [CW-1:0]                col;

  assign in_acc = in_valid && !in_stall;
  assign in_au  = in_flow_u[MW-1] ? (~in_flow_u + 1'b1) : in_flow_u;
  assign in_av  = in_flow_v[MW-1] ? (~in_flow_v + 1'b1) : in_flow_v;

  // shared multiplier: squares of u and v, then of the reference length
  always_comb begin
    case (state_r)
      S_SQ_U:  begin mul_a = LW'(au_r); mul_b = LW'(au_r); end
      S_SQ_V:  begin mul_a = LW'(av_r); mul_b = LW'(av_r); end
      default: begin mul_a = n_sel;     mul_b = n_sel;     end
    endcase
  end
  assign prod   = mul_a * mul_b;
  assign sum_sq = s_r + prod;

  always_comb begin
    if (max_motion_r != '0) begin
      n_sel = LW'(max_motion_r);
    end else if (longest_r != '0) begin
      n_sel = longest_r;
    end else begin
      n_sel = LW'(1) << fvcc_pkg::FLOW_FRAC_BITS;
    end
  end

  // quadrant mapping of the first-quadrant angle
  always_comb begin
    if (av_r == '0) begin
      q_ang = '0;
    end else if (au_r == '0) begin
      q_ang = fvcc_pkg::QANG_W'(fvcc_pkg::QUARTER_TURN);
    end else begin
      q_ang = cordic_angle;
    end
    if (!u_neg_r && !v_neg_r) begin
      phi_w = (AW+1)'(q_ang);
    end else if (u_neg_r && !v_neg_r) begin
      phi_w = (AW+1)'(fvcc_pkg::HALF_TURN) - (AW+1)'(q_ang);
    end else if (u_neg_r) begin
      phi_w = (AW+1)'(fvcc_pkg::HALF_TURN) + (AW+1)'(q_ang);
    end else begin
      phi_w = (AW+1)'(fvcc_pkg::FULL_TURN) - (AW+1)'(q_ang);
    end
    phi = phi_w[AW-1:0];
  end

  always_comb begin
    k0   = fk_r[fvcc_pkg::FK_W-1:16];
    k1   = k0 + 1'b1;
    frac = fk_r[15:0];
    omf  = 17'h10000 - {1'b0, frac};
    w0   = fvcc_pkg::wheel_ch(k0, ch_r);
    w1   = fvcc_pkg::wheel_ch(k1, ch_r);
    far3 = 27'(c_r) * 27'd3;
    shade_gap = 24'(255 * 65536) - c_r[23:0];
    near_p = NW'(rq_r) * NW'(shade_gap);
    near_v = (NW'(255) << 32) - near_p;
    col  = far_r ? far3[25:18] : near_v[39:32];
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    u_neg_nxt       = u_neg_r;
    v_neg_nxt       = v_neg_r;
    au_nxt          = au_r;
    av_nxt          = av_r;
    s_nxt           = s_r;
    n2_nxt          = n2_r;
    far_nxt         = far_r;
    rq_nxt          = rq_r;
    fk_nxt          = fk_r;
    c_nxt           = c_r;
    ch_nxt          = ch_r;
    red_nxt         = red_r;
    green_nxt       = green_r;
    blue_nxt        = blue_r;
    longest_nxt     = longest_r;
    ang_rdy_nxt     = ang_rdy_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_red_nxt     = out_red_r;
    out_green_nxt   = out_green_r;
    out_blue_nxt    = out_blue_r;
    out_longest_nxt = out_longest_r;
    unit_cmd        = '0;
    unit_a          = s_r;
    cordic_start    = 1'b0;

    if (cordic_stat.done) ang_rdy_nxt = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt  = in_mode;
          u_neg_nxt = in_flow_u[MW-1];
          v_neg_nxt = in_flow_v[MW-1];
          au_nxt    = in_au;
          av_nxt    = in_av;
          red_nxt   = '0;
          green_nxt = '0;
          blue_nxt  = '0;
          if (!in_mode && in_frame_start) longest_nxt = '0;
          if (in_mode && !in_unknown) begin
            cordic_start = 1'b1;
            ang_rdy_nxt  = 1'b0;
          end
          state_nxt = in_unknown ? S_DONE : S_SQ_U;
        end
      end
      S_SQ_U: begin
        s_nxt     = prod;
        state_nxt = S_SQ_V;
      end
      S_SQ_V: begin
        s_nxt = sum_sq;
        if (!mode_r) begin
          unit_cmd.start = 1'b1;
          unit_a         = sum_sq;
          state_nxt      = S_ROOT;
        end else begin
          state_nxt = S_NSQ;
        end
      end
      S_ROOT: begin
        if (unit_stat.done) begin
          if (unit_res[LW-1:0] > longest_r) longest_nxt = unit_res[LW-1:0];
          state_nxt = S_DONE;
        end
      end
      S_NSQ: begin
        n2_nxt    = prod;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        far_nxt = (s_r > n2_r);
        if (s_r > n2_r) begin
          state_nxt = S_ANGLE;
        end else if (s_r == n2_r) begin
          rq_nxt    = fvcc_pkg::RQ_W'(65536);
          state_nxt = S_ANGLE;
        end else begin
          unit_cmd.start  = 1'b1;
          unit_cmd.op_div = 1'b1;
          state_nxt       = S_DIV;
        end
      end
      S_DIV: begin
        if (unit_stat.done) begin
          unit_cmd.start = 1'b1;
          unit_a         = SW'(unit_res);
          state_nxt      = S_QROOT;
        end
      end
      S_QROOT: begin
        if (unit_stat.done) begin
          rq_nxt    = unit_res[fvcc_pkg::RQ_W-1:0];
          state_nxt = S_ANGLE;
        end
      end
      S_ANGLE: begin
        if (ang_rdy_r) begin
          fk_nxt    = fvcc_pkg::FK_W'(phi[AW-1:4]) * fvcc_pkg::FK_W'(fvcc_pkg::WHEEL_LAST);
          ch_nxt    = fvcc_pkg::CH_RED;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        c_nxt     = fvcc_pkg::MIX_W'(w0) * fvcc_pkg::MIX_W'(omf) +
                    fvcc_pkg::MIX_W'(w1) * fvcc_pkg::MIX_W'(frac);
        state_nxt = S_SHADE;
      end
      S_SHADE: begin
        case (ch_r)
          fvcc_pkg::CH_RED:   red_nxt   = col;
          fvcc_pkg::CH_GREEN: green_nxt = col;
          default:            blue_nxt  = col;
        endcase
        if (ch_r == fvcc_pkg::CH_BLUE) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_MIX;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_red_nxt     = red_r;
          out_green_nxt   = green_r;
          out_blue_nxt    = blue_r;
          out_longest_nxt = longest_r[15:0];
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  fvcc_root_div u_root_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (unit_cmd),
    .a_in   (unit_a),
    .div_in (n2_r),
    .stat   (unit_stat),
    .result (unit_res)
  );

  fvcc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .ax    (in_au),
    .ay    (in_av),
    .stat  (cordic_stat),
    .angle (cordic_angle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      longest_r    <= '0;
      max_motion_r <= '0;
      ang_rdy_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      longest_r   <= longest_nxt;
      ang_rdy_r   <= ang_rdy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) max_motion_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    mode_r        <= mode_nxt;
    u_neg_r       <= u_neg_nxt;
    v_neg_r       <= v_neg_nxt;
    au_r          <= au_nxt;
    av_r          <= av_nxt;
    s_r           <= s_nxt;
    n2_r          <= n2_nxt;
    far_r         <= far_nxt;
    rq_r          <= rq_nxt;
    fk_r          <= fk_nxt;
    c_r           <= c_nxt;
    ch_r          <= ch_nxt;
    red_r         <= red_nxt;
    green_r       <= green_nxt;
    blue_r        <= blue_nxt;
    out_red_r     <= out_red_nxt;
    out_green_r   <= out_green_nxt;
    out_blue_r    <= out_blue_nxt;
    out_longest_r <= out_longest_nxt;
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_red     = out_red_r;
  assign out_green   = out_green_r;
  assign out_blue    = out_blue_r;
  assign out_longest = out_longest_r;

endmodule
`default_nettype wire

// ----- rtl/fvcc_checker.sv -----
// Port-level checker for the color coder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "flow_vector_color_coder_top_assert.svh"
module fvcc_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [fvcc_pkg::COLOR_W-1:0]          out_red,
  input wire logic [fvcc_pkg::COLOR_W-1:0]          out_green,
  input wire logic [fvcc_pkg::COLOR_W-1:0]          out_blue,
  input wire logic [15:0]                           out_longest
);

  // a stalled result transaction holds
  `FVCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_longest), "stalled result changed")

  // one transaction in work at a time
  `FVCC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")

  // a result only appears at the end of work
  `FVCC_ASSERT_IMPL(a_result_after_work, $rose(out_valid), $past(in_stall), "result without work")

endmodule

bind flow_vector_color_coder_top fvcc_checker u_fvcc_checker (.*);
`default_nettype wire
